>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro assumes clk_i and rst_ni are visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define MVM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/mvm_pkg.sv
// Shared constants, codes and types of the matrix-vector multiply block.
// No dependencies; mvm_mac, the top level, the checker and the bench take names from here by scope.
package mvm_pkg;

  localparam int unsigned MAX_SIZE = 16;
  localparam int unsigned IDX_W    = $clog2(MAX_SIZE);
  localparam int unsigned DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned ACC_W    = PROD_W + IDX_W;
  localparam int unsigned FRAC_W   = 16;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_DIM   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_MAC   = 2'd2,
    ST_DRAIN = 2'd3
  } state_e;

  // Tag that travels with each multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;      // first column of a row: restart the sum
    logic             last;       // last column of a row: sum complete
    logic             final_row;  // row is the last of the product
    logic [IDX_W-1:0] row;
  } mac_ctl_t;

  // Entry (r,c) sits at r*MAX_SIZE+c whatever the size in use.
  function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_SIZE) + ADDR_W'(c);
  endfunction

endpackage

>>> hw/rtl/mvm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mvm_mac.sv
// Shared multiply-accumulate unit: multiply stage, wide accumulator,
// round half up and saturate to Q16.16. Depends on mvm_pkg.
module mvm_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvm_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [mvm_pkg::DATA_W-1:0] a_i,
  input  logic signed [mvm_pkg::DATA_W-1:0] b_i,
  output logic                              done_o,
  output logic                              final_o,
  output logic [mvm_pkg::IDX_W-1:0]         row_o,
  output logic signed [mvm_pkg::DATA_W-1:0] value_o,
  output logic                              busy_o
);

  mvm_pkg::mac_ctl_t                        ctl_s2_q;
  logic signed [mvm_pkg::PROD_W-1:0]        prod_q;
  logic signed [mvm_pkg::ACC_W-1:0]         acc_q;
  logic signed [mvm_pkg::ACC_W-1:0]         acc_d;
  logic signed [mvm_pkg::ACC_W-1:0]         prod_ext;
  logic                                     done_q;
  logic                                     final_q;
  logic [mvm_pkg::IDX_W-1:0]                row_q;
  logic signed [mvm_pkg::ACC_W-1:0]         half;
  logic signed [mvm_pkg::ACC_W-1:0]         rnd;
  logic signed [mvm_pkg::ACC_W-1:0]         shf;
  logic signed [mvm_pkg::ACC_W-1:0]         sat_hi;
  logic signed [mvm_pkg::ACC_W-1:0]         sat_lo;

  // stage 2: exact Q32.32 product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s2_q <= '0;
    end else begin
      ctl_s2_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // stage 3: exact running sum
  assign prod_ext = mvm_pkg::ACC_W'(prod_q);
  assign acc_d    = ctl_s2_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_s2_q.valid && ctl_s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_s2_q.valid) begin
      acc_q   <= acc_d;
      row_q   <= ctl_s2_q.row;
      final_q <= ctl_s2_q.final_row;
    end
  end

  // round half up to Q16.16, then clamp to 32 bits
  always_comb begin
    half                      = '0;
    half[mvm_pkg::FRAC_W-1]   = 1'b1;
    sat_hi                    = '0;
    sat_hi[mvm_pkg::DATA_W-2:0] = '1;
    sat_lo                    = ~sat_hi;
    rnd                       = acc_q + half;
    shf                       = rnd >>> mvm_pkg::FRAC_W;
    if (shf > sat_hi) begin
      value_o = sat_hi[mvm_pkg::DATA_W-1:0];
    end else if (shf < sat_lo) begin
      value_o = sat_lo[mvm_pkg::DATA_W-1:0];
    end else begin
      value_o = shf[mvm_pkg::DATA_W-1:0];
    end
  end

  assign done_o  = done_q;
  assign final_o = final_q;
  assign row_o   = row_q;
  assign busy_o  = ctl_s2_q.valid || done_q;

endmodule

>>> hw/rtl/matrix_vector_multiply.sv
// Matrix-vector multiply, Q16.16. Write, clear and vector load are done when taken (a
// last load may start a product); a read holds the block in ST_READ, where its result
// is formed for the result register. A product walks the N*N entries row by row
// through one MAC; rows come out in order, block free again once the MAC has drained.
// Errors come out the cycle after the transaction. Results cannot be stalled.
// Reset: matrix reads as zero via per-entry valid flags (no clearing pass), N = 16.
module matrix_vector_multiply (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode_i,
  input  logic [mvm_pkg::IDX_W-1:0]         row_i,
  input  logic [mvm_pkg::IDX_W-1:0]         column_i,
  input  logic signed [mvm_pkg::DATA_W-1:0] value_i,
  input  logic                              vector_end_i,
  // size register
  input  logic                              size_in_use_we_i,
  input  logic [mvm_pkg::SIZE_W-1:0]        size_in_use_i,
  // result channel
  output logic                              result_valid_o,
  output logic signed [mvm_pkg::DATA_W-1:0] result_value_o,
  output logic [mvm_pkg::IDX_W-1:0]         result_row_o,
  output logic [1:0]                        status_o,
  output logic                              final_flag_o
);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  mvm_pkg::state_e                          state_q, state_d;
  mvm_pkg::mode_e                           mode;
  logic [mvm_pkg::SIZE_W-1:0]               size_q;
  logic [mvm_pkg::SIZE_W-1:0]               n;
  logic [mvm_pkg::IDX_W-1:0]                n_m1;
  logic                                     accept;
  logic                                     row_ok;
  logic                                     col_ok;

  // sequencer position
  logic [mvm_pkg::IDX_W-1:0]                row_q, row_d;
  logic [mvm_pkg::IDX_W-1:0]                col_q, col_d;

  // vector buffer and element count
  logic signed [mvm_pkg::DATA_W-1:0]        vec_q [mvm_pkg::MAX_SIZE];
  logic                                     vec_we;
  logic [mvm_pkg::COUNT_W-1:0]              vcount_q, vcount_d;
  logic [mvm_pkg::COUNT_W-1:0]              cnt_inc;

  // matrix store and its per-entry valid flags
  logic [mvm_pkg::DEPTH-1:0]                entry_valid_q;
  logic                                     ram_we;
  logic                                     clear_all;
  logic [mvm_pkg::ADDR_W-1:0]               ram_waddr;
  logic [mvm_pkg::ADDR_W-1:0]               ram_raddr;
  logic [mvm_pkg::DATA_W-1:0]               ram_rdata;
  logic                                     rd_valid_q;
  logic signed [mvm_pkg::DATA_W-1:0]        mat_a;

  // MAC feed (stage 1)
  mvm_pkg::mac_ctl_t                        ctl_s1_q, ctl_s1_d;
  logic signed [mvm_pkg::DATA_W-1:0]        vec_s1_q;
  logic                                     mac_done;
  logic                                     mac_final;
  logic [mvm_pkg::IDX_W-1:0]                mac_row;
  logic signed [mvm_pkg::DATA_W-1:0]        mac_value;
  logic                                     mac_busy;

  // result register
  logic                                     out_valid_q, out_valid_d;
  logic signed [mvm_pkg::DATA_W-1:0]        out_value_q, out_value_d;
  logic [mvm_pkg::IDX_W-1:0]                out_row_q, out_row_d;
  mvm_pkg::status_e                         out_status_q, out_status_d;
  logic                                     out_final_q, out_final_d;

  // ---------------------------------------------------------------------------
  // Size in use and bounds. Zero behaves as 1, anything above the built size
  // as the built size.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (size_q == '0) begin
      n = mvm_pkg::SIZE_W'(1);
    end else if (size_q > mvm_pkg::SIZE_W'(mvm_pkg::MAX_SIZE)) begin
      n = mvm_pkg::SIZE_W'(mvm_pkg::MAX_SIZE);
    end else begin
      n = size_q;
    end
  end

  assign n_m1   = mvm_pkg::IDX_W'(n - mvm_pkg::SIZE_W'(1));
  assign row_ok = mvm_pkg::SIZE_W'(row_i) < n;
  assign col_ok = mvm_pkg::SIZE_W'(column_i) < n;
  assign mode   = mvm_pkg::mode_e'(mode_i);
  assign busy   = (state_q != mvm_pkg::ST_IDLE);
  assign accept = start && !busy;

  // count saturates at its top code
  assign cnt_inc = (vcount_q == '1) ? vcount_q : vcount_q + mvm_pkg::COUNT_W'(1);

  // ---------------------------------------------------------------------------
  // Matrix store. Reads come from the command during idle and from the
  // sequencer during a product; the valid flag is registered with the read data.
  // ---------------------------------------------------------------------------
  assign ram_waddr = mvm_pkg::mat_addr(row_i, column_i);
  assign ram_raddr = (state_q == mvm_pkg::ST_MAC) ? mvm_pkg::mat_addr(row_q, col_q)
                                                  : mvm_pkg::mat_addr(row_i, column_i);

  mvm_ram #(
    .WIDTH (mvm_pkg::DATA_W),
    .DEPTH (mvm_pkg::DEPTH)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // an entry not written since reset or the last clear reads as zero
  assign mat_a = rd_valid_q ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (clear_all) begin
        entry_valid_q <= '0;
      end else if (ram_we) begin
        entry_valid_q[ram_waddr] <= 1'b1;
      end
      rd_valid_q <= entry_valid_q[ram_raddr];
    end
  end

  // vector buffer: no reset; that every element used by a product has been loaded is up to the user, not enforced here
  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_q[column_i] <= value_i;
    end
    vec_s1_q <= vec_q[col_q];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvm_pkg::ST_IDLE;
      size_q      <= mvm_pkg::SIZE_W'(mvm_pkg::MAX_SIZE);
      vcount_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      ctl_s1_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ctl_s1_q    <= ctl_s1_d;
      out_valid_q <= out_valid_d;
      if (size_in_use_we_i) begin
        size_q <= size_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_row_q    <= out_row_d;
    out_status_q <= out_status_d;
    out_final_q  <= out_final_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Idle decodes the transaction; single results (errors) go
  // straight to the result register. A product steps column by column, row
  // by row, one MAC issue per cycle, then drains the MAC pipeline.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    vcount_d     = vcount_q;
    ctl_s1_d     = '0;
    ram_we       = 1'b0;
    clear_all    = 1'b0;
    vec_we       = 1'b0;
    out_valid_d  = 1'b0;
    out_value_d  = out_value_q;
    out_row_d    = out_row_q;
    out_status_d = out_status_q;
    out_final_d  = out_final_q;

    unique case (state_q)
      mvm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            mvm_pkg::MODE_WRITE: begin
              if (row_ok && col_ok) begin
                ram_we = 1'b1;
              end else begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_row_d    = row_i;
                out_status_d = mvm_pkg::STATUS_RANGE;
                out_final_d  = 1'b1;
              end
            end
            mvm_pkg::MODE_READ: begin
              out_row_d = row_i;
              if (row_ok && col_ok) begin
                state_d = mvm_pkg::ST_READ;
              end else begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = mvm_pkg::STATUS_RANGE;
                out_final_d  = 1'b1;
              end
            end
            mvm_pkg::MODE_LOAD: begin
              if (!col_ok) begin
                // element dropped and the partial vector abandoned
                vcount_d     = '0;
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_row_d    = '0;
                out_status_d = mvm_pkg::STATUS_RANGE;
                out_final_d  = 1'b1;
              end else begin
                vec_we   = 1'b1;
                vcount_d = cnt_inc;
                if (vector_end_i) begin
                  vcount_d = '0;
                  if (cnt_inc != n) begin
                    out_valid_d  = 1'b1;
                    out_value_d  = '0;
                    out_row_d    = '0;
                    out_status_d = mvm_pkg::STATUS_DIM;
                    out_final_d  = 1'b1;
                  end else begin
                    state_d = mvm_pkg::ST_MAC;
                    row_d   = '0;
                    col_d   = '0;
                  end
                end
              end
            end
            mvm_pkg::MODE_CLEAR: begin
              clear_all = 1'b1;
            end
            default: begin
              clear_all = 1'b0;
            end
          endcase
        end
      end

      mvm_pkg::ST_READ: begin
        out_valid_d  = 1'b1;
        out_value_d  = mat_a;
        out_status_d = mvm_pkg::STATUS_OK;
        out_final_d  = 1'b1;
        state_d      = mvm_pkg::ST_IDLE;
      end

      mvm_pkg::ST_MAC: begin
        ctl_s1_d.valid     = 1'b1;
        ctl_s1_d.first     = (col_q == '0);
        ctl_s1_d.last      = (col_q == n_m1);
        ctl_s1_d.final_row = (row_q == n_m1);
        ctl_s1_d.row       = row_q;
        if (col_q == n_m1) begin
          col_d = '0;
          if (row_q == n_m1) begin
            state_d = mvm_pkg::ST_DRAIN;
          end else begin
            row_d = row_q + mvm_pkg::IDX_W'(1);
          end
        end else begin
          col_d = col_q + mvm_pkg::IDX_W'(1);
        end
      end

      mvm_pkg::ST_DRAIN: begin
        if (!ctl_s1_q.valid && !mac_busy) begin
          state_d = mvm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mvm_pkg::ST_IDLE;
      end
    endcase

    // finished row sums; only ever during a product
    if (mac_done) begin
      out_valid_d  = 1'b1;
      out_value_d  = mac_value;
      out_row_d    = mac_row;
      out_status_d = mvm_pkg::STATUS_OK;
      out_final_d  = mac_final;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared MAC unit
  // ---------------------------------------------------------------------------
  mvm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_s1_q),
    .a_i     (mat_a),
    .b_i     (vec_s1_q),
    .done_o  (mac_done),
    .final_o (mac_final),
    .row_o   (mac_row),
    .value_o (mac_value),
    .busy_o  (mac_busy)
  );

  // ---------------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------------
  assign result_valid_o = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_row_o   = out_row_q;
  assign status_o       = out_status_q;
  assign final_flag_o   = out_final_q;

endmodule

>>> hw/rtl/mvm_checker.sv
// Port-level checks of the matrix-vector multiply block, bound to its top level.
// Depends on mvm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        mode_i,
  input logic                              result_valid_o,
  input logic signed [mvm_pkg::DATA_W-1:0] result_value_o,
  input logic [mvm_pkg::IDX_W-1:0]         result_row_o,
  input logic [1:0]                        status_o,
  input logic                              final_flag_o
);

  // a clear never produces a result
  `MVM_ASSERT(a_clear_silent, (start && !busy && mode_i == mvm_pkg::MODE_CLEAR) |=> !result_valid_o, "clear transaction produced a result")

  // error results are single and therefore final
  `MVM_ASSERT(a_error_final, (result_valid_o && status_o != mvm_pkg::STATUS_OK) |-> final_flag_o, "error result without final flag")

  // more product rows follow a non-final result, so the block stays busy
  `MVM_ASSERT(a_more_rows_busy, (result_valid_o && !final_flag_o) |=> busy, "block went idle in the middle of a product")

  // a dimension mismatch carries value zero on row zero
  `MVM_ASSERT_NEVER(a_dim_zero, result_valid_o && status_o == mvm_pkg::STATUS_DIM && (result_value_o != '0 || result_row_o != '0), "mismatch result with non-zero payload")

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .result_value_o (result_value_o),
  .result_row_o   (result_row_o),
  .status_o       (status_o),
  .final_flag_o   (final_flag_o)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for matrix_vector_multiply: a shadow of the matrix, the vector buffer
// and the row products checks every result; directed commands first, then randomised streams.
// Depends on mvm_pkg and the block's RTL only.

typedef struct packed {
  logic signed [31:0] value;
  logic [3:0]         row;
  mvm_pkg::status_e   status;
  logic               fin;
} row_result_t;

// Shadow of the block's storage; works out the results each command transaction owes.
class mvm_shadow;
  logic signed [31:0] matrix_copy [mvm_pkg::DEPTH];
  logic signed [31:0] vector_copy [mvm_pkg::MAX_SIZE];
  int unsigned        loaded;
  logic [4:0]         size_reg;
  row_result_t        owed_q [$];
  int unsigned        faults;
  int unsigned        checked;
  int unsigned        products;

  function new();
    foreach (matrix_copy[i]) matrix_copy[i] = '0;
    foreach (vector_copy[i]) vector_copy[i] = '0;
    loaded   = 0;
    size_reg = 5'd16;
    faults   = 0;
    checked  = 0;
    products = 0;
  endfunction

  function void set_size(logic [4:0] s);
    size_reg = s;
  endfunction

  function int unsigned dim();
    if (size_reg == 5'd0) return 1;
    if (32'(size_reg) > mvm_pkg::MAX_SIZE) return mvm_pkg::MAX_SIZE;
    return 32'(size_reg);
  endfunction

  function int unsigned owed();
    return owed_q.size();
  endfunction

  function void owe(logic signed [31:0] v, logic [3:0] r, mvm_pkg::status_e st, logic f);
    row_result_t e;
    e.value  = v;
    e.row    = r;
    e.status = st;
    e.fin    = f;
    owed_q.push_back(e);
  endfunction

  // Exact Q32.32 sum, rounded half up to Q16.16, saturated to 32 bits
  function logic signed [31:0] row_dot(int unsigned r, int unsigned n);
    logic signed [71:0] acc;
    logic signed [71:0] rounded;
    longint             term;
    acc = '0;
    for (int unsigned j = 0; j < n; j++) begin
      term = longint'(matrix_copy[r * mvm_pkg::MAX_SIZE + j]) * longint'(vector_copy[j]);
      acc  = acc + 72'(term);
    end
    rounded = (acc + 72'sd32768) >>> 16;
    if (rounded > 72'sd2147483647) return 32'sh7FFF_FFFF;
    if (rounded < -72'sd2147483648) return 32'sh8000_0000;
    return rounded[31:0];
  endfunction

  function void take_command(mvm_pkg::mode_e m, logic [3:0] r, logic [3:0] c,
                             logic signed [31:0] v, logic vend);
    int unsigned n;
    int unsigned ri;
    int unsigned ci;
    n  = dim();
    ri = 32'(r);
    ci = 32'(c);
    case (m)
      mvm_pkg::MODE_WRITE: begin
        if (ri < n && ci < n) matrix_copy[ri * mvm_pkg::MAX_SIZE + ci] = v;
        else owe('0, r, mvm_pkg::STATUS_RANGE, 1'b1);
      end
      mvm_pkg::MODE_READ: begin
        if (ri < n && ci < n)
          owe(matrix_copy[ri * mvm_pkg::MAX_SIZE + ci], r, mvm_pkg::STATUS_OK, 1'b1);
        else owe('0, r, mvm_pkg::STATUS_RANGE, 1'b1);
      end
      mvm_pkg::MODE_LOAD: begin
        if (ci >= n) begin
          loaded = 0;
          owe('0, '0, mvm_pkg::STATUS_RANGE, 1'b1);
        end else begin
          vector_copy[c] = v;
          if (loaded < 31) loaded++;
          if (vend) begin
            if (loaded != n) owe('0, '0, mvm_pkg::STATUS_DIM, 1'b1);
            else begin
              products++;
              for (int unsigned i = 0; i < n; i++)
                owe(row_dot(i, n), i[3:0], mvm_pkg::STATUS_OK, i + 1 == n);
            end
            loaded = 0;
          end
        end
      end
      default: foreach (matrix_copy[i]) matrix_copy[i] = '0;
    endcase
  endfunction

  function void compare_result(logic signed [31:0] v, logic [3:0] r, logic [1:0] st, logic f);
    row_result_t e;
    checked++;
    if (owed_q.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("%0t: unexpected result value %h row %0d status %0d final %b",
                 $time, v, r, st, f);
      return;
    end
    e = owed_q.pop_front();
    if (v !== e.value || r !== e.row || st !== e.status || f !== e.fin) begin
      faults++;
      if (faults <= 10)
        $display("%0t: expected value %h row %0d status %0d final %b, got %h %0d %0d %b",
                 $time, e.value, e.row, e.status, e.fin, v, r, st, f);
    end
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 8;    // write, clear and load finish as soon as they are taken
  localparam int unsigned DRAIN       = 300;  // covers a full 16x16 product walk
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 50;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         mode_i;
  logic [3:0]         row_i;
  logic [3:0]         column_i;
  logic signed [31:0] value_i;
  logic               vector_end_i;
  logic               size_in_use_we_i;
  logic [4:0]         size_in_use_i;
  logic               result_valid_o;
  logic signed [31:0] result_value_o;
  logic [3:0]         result_row_o;
  logic [1:0]         status_o;
  logic               final_flag_o;

  mvm_shadow   shadow;
  int unsigned sent;
  int unsigned burst_left;
  bit          eager;          // no gaps at all in this phase
  int unsigned cycle_count;
  logic [4:0]  plan [PHASES];

  matrix_vector_multiply dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .value_i          (value_i),
    .vector_end_i     (vector_end_i),
    .size_in_use_we_i (size_in_use_we_i),
    .size_in_use_i    (size_in_use_i),
    .result_valid_o   (result_valid_o),
    .result_value_o   (result_value_o),
    .result_row_o     (result_row_o),
    .status_o         (status_o),
    .final_flag_o     (final_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      shadow.compare_result(result_value_o, result_row_o, status_o, final_flag_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired, %0d results still owed", shadow.owed());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Mix of extremes, small Q16.16 numbers near zero and raw random words
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3, 4, 5: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      6:       return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Sender works in bursts; between bursts start drops for a random gap, except in an eager phase.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (!eager && gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // One command transaction; start is left high so back-to-back transactions need no
  // second assignment in the same step.
  task automatic issue(input mvm_pkg::mode_e m, input logic [3:0] r, input logic [3:0] c,
                       input logic signed [31:0] v, input logic vend);
    pace();
    start        <= 1'b1;
    mode_i       <= m;
    row_i        <= r;
    column_i     <= c;
    value_i      <= v;
    vector_end_i <= vend;
    do @(posedge clk_i); while (busy);
    shadow.take_command(m, r, c, v, vend);
    sent++;
  endtask

  // Size changes only once the block has gone quiet.
  task automatic retune_size(input logic [4:0] s);
    start <= 1'b0;
    while (shadow.owed() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    size_in_use_we_i <= 1'b1;
    size_in_use_i    <= s;
    @(posedge clk_i);
    size_in_use_we_i <= 1'b0;
    shadow.set_size(s);
  endtask

  // Well-formed vector: every index once, in order or shuffled, end marker on the last.
  task automatic full_vector();
    int unsigned n;
    int unsigned order [16];
    int unsigned j;
    int unsigned tmp;
    n = shadow.dim();
    for (int unsigned i = 0; i < n; i++) order[i] = i;
    if ($urandom_range(0, 1))
      for (int unsigned i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    for (int unsigned i = 0; i < n; i++)
      issue(mvm_pkg::MODE_LOAD, 4'($urandom), 4'(order[i]), pick_value(), i + 1 == n);
  endtask

  // Wrong length, sometimes with an index past N somewhere inside.
  task automatic broken_vector();
    int unsigned n;
    int unsigned len;
    int unsigned spoil;
    int unsigned c;
    n   = shadow.dim();
    len = $urandom_range(1, n + 3);
    if (len == n) len++;
    spoil = len;
    if (n < 16 && $urandom_range(0, 2) == 0) spoil = $urandom_range(0, len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      c = (i == spoil) ? $urandom_range(n, 15) : $urandom_range(0, n - 1);
      issue(mvm_pkg::MODE_LOAD, 4'($urandom), 4'(c), pick_value(), i + 1 == len);
    end
  endtask

  // Runs the element count into its ceiling of 31 before the end marker.
  task automatic long_vector();
    int unsigned n;
    n = shadow.dim();
    repeat ($urandom_range(32, 36))
      issue(mvm_pkg::MODE_LOAD, 4'($urandom), 4'($urandom_range(0, n - 1)), pick_value(),
            1'b0);
    issue(mvm_pkg::MODE_LOAD, 4'($urandom), 4'($urandom_range(0, n - 1)), pick_value(), 1'b1);
  endtask

  // Anything at all apart from a clear: indices may land out of bounds.
  task automatic noise_item();
    mvm_pkg::mode_e m;
    case ($urandom_range(0, 2))
      0:       m = mvm_pkg::MODE_WRITE;
      1:       m = mvm_pkg::MODE_READ;
      default: m = mvm_pkg::MODE_LOAD;
    endcase
    issue(m, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned n;
    int unsigned phase_end;
    int unsigned kind;
    shadow           = new();
    sent             = 0;
    burst_left       = 0;
    eager            = 1'b0;
    cycle_count      = 0;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    mode_i           <= mvm_pkg::MODE_WRITE;
    row_i            <= '0;
    column_i         <= '0;
    value_i          <= '0;
    vector_end_i     <= 1'b0;
    size_in_use_we_i <= 1'b0;
    size_in_use_i    <= 5'd16;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at the reset size of 16. Row 0 is built to saturate high, row 15 low,
    // and the rest read the zeroed store. Loading all 16 elements here also means no
    // product later on can touch a vector entry that was never written.
    issue(mvm_pkg::MODE_WRITE, 4'd0, 4'd0, 32'sh8000_0000, 1'b0);
    issue(mvm_pkg::MODE_WRITE, 4'd0, 4'd1, 32'sh8000_0000, 1'b0);
    issue(mvm_pkg::MODE_WRITE, 4'd15, 4'd15, 32'sh7FFF_FFFF, 1'b0);
    issue(mvm_pkg::MODE_READ, 4'd0, 4'd0, '0, 1'b0);
    for (int unsigned i = 0; i < 16; i++)
      issue(mvm_pkg::MODE_LOAD, 4'd0, i[3:0],
            (i < 2 || i == 15) ? 32'sh8000_0000 : pick_value(), i == 15);

    // Directed error cases on a 2x2 matrix, then a clear and a read of a cleared entry.
    retune_size(5'd2);
    issue(mvm_pkg::MODE_WRITE, 4'd2, 4'd0, 32'sh0001_0000, 1'b0);
    issue(mvm_pkg::MODE_READ, 4'd0, 4'd15, '0, 1'b0);
    issue(mvm_pkg::MODE_LOAD, 4'd0, 4'd2, 32'sh0001_0000, 1'b1);
    issue(mvm_pkg::MODE_LOAD, 4'd0, 4'd0, 32'sh0001_0000, 1'b1);
    issue(mvm_pkg::MODE_CLEAR, 4'd0, 4'd0, '0, 1'b0);
    issue(mvm_pkg::MODE_READ, 4'd0, 4'd1, '0, 1'b0);

    // Random phases, each at its own size: both ends, zero (taken as 1), 31 (taken as 16).
    plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd0, 5'd2, 5'd9, 5'd0};
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == 5 || p == 8) plan[p] = 5'($urandom_range(0, 31));
      retune_size(plan[p]);
      eager     = ($urandom_range(0, 3) == 0);
      phase_end = sent + PHASE_ITEMS;
      if (p == 3) long_vector();
      while (sent < phase_end) begin
        n    = shadow.dim();
        kind = $urandom_range(0, 99);
        if (kind < 30) full_vector();
        else if (kind < 55)
          repeat ($urandom_range(1, 6))
            issue(mvm_pkg::MODE_WRITE, 4'($urandom_range(0, n - 1)),
                  4'($urandom_range(0, n - 1)), pick_value(), 1'($urandom_range(0, 1)));
        else if (kind < 65)
          repeat ($urandom_range(1, 3))
            issue(mvm_pkg::MODE_READ, 4'($urandom_range(0, n - 1)),
                  4'($urandom_range(0, n - 1)), pick_value(), 1'($urandom_range(0, 1)));
        else if (kind < 80) noise_item();
        else if (kind < 92) broken_vector();
        else if (kind < 96) issue(mvm_pkg::MODE_CLEAR, 4'($urandom), 4'($urandom),
                                  pick_value(), 1'($urandom_range(0, 1)));
        else long_vector();
      end
    end

    start <= 1'b0;
    while (shadow.owed() != 0 || busy) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Summary: %0d command transactions over %0d size settings, %0d products",
             sent, PHASES + 2, shadow.products);
    $display("Summary: %0d results checked, %0d faults", shadow.checked, shadow.faults);
    if (shadow.faults == 0 && shadow.owed() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_ram.sv
hw/rtl/mvm_mac.sv
hw/rtl/matrix_vector_multiply.sv
hw/rtl/mvm_checker.sv
bench/tb.sv
